// File: rtl/core/ppdc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppdc_pkg
// Shared widths, limits and codes of the pwm prescale / period / duty engine.
// ----------------------------------------------------------------------------
package ppdc_pkg;

	localparam int CHANNELS       = 8;
	localparam int CH_W           = 3;
	localparam int FREQ_W         = 27;
	localparam int PCT_W          = 7;
	localparam int CNT16_W        = 16;
	localparam int PRESC_W        = 8;
	localparam int PERIOD_MAX     = 65535;
	localparam int PRESCALE_LIMIT = 256;
	localparam int CLOCK_RESET    = 24000000;
	localparam int PCT_FULL       = 100;

	// shared restoring divider: 27-bit dividend, divisor below 256 * 2^27
	localparam int DIVD_W    = 27;
	localparam int DIVS_W    = 35;
	localparam int DIV_STEPS = DIVD_W;
	localparam int CNT_W     = 5;
	localparam int DUTY_W    = PCT_W + CNT16_W;

	typedef logic [1:0] action_t;
	localparam action_t ACT_CONFIG = 2'd0;
	localparam action_t ACT_DUTY   = 2'd1;
	localparam action_t ACT_FREQ   = 2'd2;
	localparam action_t ACT_NONE   = 2'd3;

	typedef logic [1:0] status_t;
	localparam status_t STAT_OK       = 2'd0;
	localparam status_t STAT_BAD_FREQ = 2'd1;
	localparam status_t STAT_BAD_PCT  = 2'd2;
	localparam status_t STAT_NO_CHAN  = 2'd3;

endpackage
`default_nettype wire

// File: rtl/core/pwm_prescale_period_duty_calc.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwm_prescale_period_duty_calc
// Per-channel pwm setting engine: prescale, period and active count.
// ----------------------------------------------------------------------------
// Requests enter on the in_valid / in_ready channel, one item at a time;
// in_ready is high only while the engine is idle. Each item gives exactly
// one result on out_valid / out_ready, held in an output register.
// All arithmetic runs through one restoring divider that produces one
// quotient bit per cycle:
//   configure / set frequency: q = src/f, k = ceil(q/65535), n = src/(k*f),
//     three divisions in turn
//   set duty (and set frequency with f = 0): one division by 100
//   error caught by the input checks, unused action: no division;
//     a frequency rejected by a division ends after that division
// A new item is taken once the result has moved into the output register,
// so an item holds the engine through its divisions plus any output stall.
// If the receiver stalls, the finished result waits inside the engine until
// the output register frees up; nothing is dropped.
// Reset sets the source clock to 24 MHz and marks every channel as not
// configured. cfg_wr_en writes the source clock; write it only when idle.
// ----------------------------------------------------------------------------
module pwm_prescale_period_duty_calc
	import ppdc_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_wr_en,
	input  wire logic [FREQ_W-1:0]   cfg_wr_data,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [1:0]          action,
	input  wire logic [CH_W-1:0]     channel,
	input  wire logic [FREQ_W-1:0]   frequency_hz,
	input  wire logic [PCT_W-1:0]    duty_percent,
	input  wire logic                invert_polarity,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [1:0]               status,
	output logic [PRESC_W-1:0]       prescale_minus_one,
	output logic [CNT16_W-1:0]       period_minus_one,
	output logic [CNT16_W-1:0]       active_count,
	output logic                     active_level
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_CHECK  = 4'd1;
	localparam logic [3:0] S_DIVQ   = 4'd2;
	localparam logic [3:0] S_DIVK   = 4'd3;
	localparam logic [3:0] S_MULT   = 4'd4;
	localparam logic [3:0] S_DIVN   = 4'd5;
	localparam logic [3:0] S_DUTY   = 4'd6;
	localparam logic [3:0] S_DIVA   = 4'd7;
	localparam logic [3:0] S_FINISH = 4'd8;

	logic [3:0]          state_q;
	logic [FREQ_W-1:0]   src_clk_q;

	// captured item
	action_t             act_q;
	logic [CH_W-1:0]     ch_q;
	logic [FREQ_W-1:0]   freq_q;
	logic [PCT_W-1:0]    pct_q;
	logic                inv_q;

	// per-channel settings
	logic [CNT16_W-1:0]  period_q [CHANNELS];
	logic [PRESC_W-1:0]  presc_q  [CHANNELS];
	logic [CHANNELS-1:0] polarity_q;
	logic [CHANNELS-1:0] enabled_q;

	// working values
	status_t             stat_q;
	logic [PRESC_W-1:0]  km1_q;
	logic [CNT16_W-1:0]  n_q;
	logic [CNT16_W-1:0]  active_q;
	logic                pol_q;

	// divider
	logic [DIVD_W-1:0]   dvd_q;
	logic [DIVS_W-1:0]   dsr_q;
	logic [DIVS_W-1:0]   rem_q;
	logic [DIVD_W-1:0]   quo_q;
	logic [CNT_W-1:0]    cnt_q;

	logic [DIVS_W:0]     rem_sh;
	logic                div_ge;
	logic [DIVS_W:0]     rem_diff;
	logic [DIVD_W-1:0]   quo_nx;
	logic                div_last;

	logic [PRESC_W:0]    k_full;
	logic [DIVS_W-1:0]   k_prod;
	logic [DUTY_W-1:0]   duty_prod;
	logic                fields_on;
	logic                out_free;

	// one quotient bit per cycle
	always_comb begin
		rem_sh   = {rem_q, dvd_q[DIVD_W-1]};
		div_ge   = rem_sh >= {1'b0, dsr_q};
		rem_diff = rem_sh - {1'b0, dsr_q};
		quo_nx   = {quo_q[DIVD_W-2:0], div_ge};
		div_last = cnt_q == '0;
	end

	assign k_full    = {1'b0, km1_q} + {{PRESC_W{1'b0}}, 1'b1};
	assign k_prod    = {{(DIVS_W-PRESC_W-1){1'b0}}, k_full}
	                 * {{(DIVS_W-FREQ_W){1'b0}}, freq_q};
	assign duty_prod = {{CNT16_W{1'b0}}, pct_q} * {{PCT_W{1'b0}}, n_q};

	assign fields_on = (stat_q == STAT_OK) && (act_q != ACT_NONE);
	assign out_free  = !out_valid || out_ready;
	assign in_ready  = state_q == S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q            <= S_IDLE;
			src_clk_q          <= FREQ_W'(CLOCK_RESET);
			enabled_q          <= '0;
			polarity_q         <= '0;
			out_valid          <= 1'b0;
			status             <= STAT_OK;
			prescale_minus_one <= '0;
			period_minus_one   <= '0;
			active_count       <= '0;
			active_level       <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				src_clk_q <= cfg_wr_data;
			end
			// the finish state reloads the output register itself
			if (out_valid && out_ready && state_q != S_FINISH) begin
				out_valid <= 1'b0;
			end

			// divider advances in every division state up to its last bit
			if ((state_q == S_DIVQ || state_q == S_DIVK || state_q == S_DIVN ||
			    state_q == S_DIVA) && !div_last) begin
				rem_q <= div_ge ? rem_diff[DIVS_W-1:0] : rem_sh[DIVS_W-1:0];
				quo_q <= quo_nx;
				dvd_q <= {dvd_q[DIVD_W-2:0], 1'b0};
				cnt_q <= cnt_q - {{(CNT_W-1){1'b0}}, 1'b1};
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						act_q   <= action;
						ch_q    <= channel;
						freq_q  <= frequency_hz;
						pct_q   <= duty_percent;
						inv_q   <= invert_polarity;
						stat_q  <= STAT_OK;
						km1_q   <= '0;
						n_q     <= '0;
						active_q <= '0;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					pol_q <= (act_q == ACT_CONFIG) ? ~inv_q : polarity_q[ch_q];
					priority if (act_q == ACT_NONE) begin
						state_q <= S_FINISH;
					end else if (32'(ch_q) >= CHANNELS) begin
						stat_q  <= STAT_NO_CHAN;
						state_q <= S_FINISH;
					end else if (act_q == ACT_CONFIG && freq_q == '0) begin
						stat_q  <= STAT_BAD_FREQ;
						state_q <= S_FINISH;
					end else if (act_q != ACT_CONFIG && !enabled_q[ch_q]) begin
						stat_q  <= STAT_NO_CHAN;
						state_q <= S_FINISH;
					end else if (act_q == ACT_DUTY || (act_q == ACT_FREQ && freq_q == '0))
					begin
						// zero frequency reads as zero percent duty
						if (act_q == ACT_FREQ) begin
							pct_q <= '0;
						end
						if (act_q == ACT_DUTY && pct_q > PCT_W'(PCT_FULL)) begin
							stat_q  <= STAT_BAD_PCT;
							state_q <= S_FINISH;
						end else begin
							n_q     <= period_q[ch_q];
							km1_q   <= presc_q[ch_q];
							state_q <= S_DUTY;
						end
					end else begin
						dvd_q   <= src_clk_q;
						dsr_q   <= {{(DIVS_W-FREQ_W){1'b0}}, freq_q};
						rem_q   <= '0;
						quo_q   <= '0;
						cnt_q   <= CNT_W'(DIV_STEPS - 1);
						state_q <= S_DIVQ;
					end
				end
				S_DIVQ: begin
					if (div_last) begin
						// q past 256 full periods needs k above the limit
						if (quo_nx == '0 ||
						    quo_nx > DIVD_W'(PRESCALE_LIMIT * PERIOD_MAX)) begin
							stat_q  <= STAT_BAD_FREQ;
							state_q <= S_FINISH;
						end else begin
							// ceil(q / 65535)
							dvd_q   <= quo_nx + DIVD_W'(PERIOD_MAX - 1);
							dsr_q   <= DIVS_W'(PERIOD_MAX);
							rem_q   <= '0;
							quo_q   <= '0;
							cnt_q   <= CNT_W'(DIV_STEPS - 1);
							state_q <= S_DIVK;
						end
					end
				end
				S_DIVK: begin
					if (div_last) begin
						if (quo_nx > DIVD_W'(PRESCALE_LIMIT)) begin
							stat_q  <= STAT_BAD_FREQ;
							state_q <= S_FINISH;
						end else begin
							km1_q   <= PRESC_W'(quo_nx - DIVD_W'(1));
							state_q <= S_MULT;
						end
					end
				end
				S_MULT: begin
					dvd_q   <= src_clk_q;
					dsr_q   <= k_prod;
					rem_q   <= '0;
					quo_q   <= '0;
					cnt_q   <= CNT_W'(DIV_STEPS - 1);
					state_q <= S_DIVN;
				end
				S_DIVN: begin
					if (div_last) begin
						if (quo_nx == '0 || quo_nx >= DIVD_W'(PERIOD_MAX)) begin
							stat_q <= STAT_BAD_FREQ;
						end else begin
							n_q <= quo_nx[CNT16_W-1:0];
							// fifty percent of n is n halved
							active_q <= (act_q == ACT_FREQ) ? quo_nx[CNT16_W:1] : '0;
						end
						state_q <= S_FINISH;
					end
				end
				S_DUTY: begin
					dvd_q   <= {{(DIVD_W-DUTY_W){1'b0}}, duty_prod};
					dsr_q   <= DIVS_W'(PCT_FULL);
					rem_q   <= '0;
					quo_q   <= '0;
					cnt_q   <= CNT_W'(DIV_STEPS - 1);
					state_q <= S_DIVA;
				end
				S_DIVA: begin
					if (div_last) begin
						active_q <= quo_nx[CNT16_W-1:0];
						state_q  <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						out_valid          <= 1'b1;
						status             <= stat_q;
						prescale_minus_one <= fields_on ? km1_q : '0;
						period_minus_one   <= fields_on ? (n_q - CNT16_W'(1)) : '0;
						active_count       <= fields_on ? active_q : '0;
						active_level       <= fields_on ? pol_q : 1'b0;
						if (stat_q == STAT_OK &&
						    (act_q == ACT_CONFIG || (act_q == ACT_FREQ && freq_q != '0))) begin
							period_q[ch_q] <= n_q;
							presc_q[ch_q]  <= km1_q;
							if (act_q == ACT_CONFIG) begin
								polarity_q[ch_q] <= pol_q;
								enabled_q[ch_q]  <= 1'b1;
							end
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the pwm prescale / period / duty engine.
// ----------------------------------------------------------------------------
// Requests go in on the valid/ready request channel and results come back on
// the result channel. Both sides idle at random. A bench-side model of the
// per-channel period, prescale, polarity and configured mask predicts each
// result when its request is accepted. Results are checked field by field in
// order. The source clock register is swept through several values between
// phases, written only while the engine is idle.
// ----------------------------------------------------------------------------
module tb;
	import ppdc_pkg::*;

	localparam int CYCLE_LIMIT = 600000;   // ~1350 items, taken 4x over
	localparam int DRAIN_CYCLES = 100;     // longer than the three-division path
	localparam int HALF_DUTY = 50;
	localparam int PCT_TOP = 127;

	typedef struct packed {
		status_t              status;
		logic [PRESC_W-1:0]   prescale_m1;
		logic [CNT16_W-1:0]   period_m1;
		logic [CNT16_W-1:0]   active;
		logic                 high;
	} pwm_result_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [FREQ_W-1:0]   cfg_wr_data;
	logic                in_valid;
	logic                in_ready;
	action_t             action;
	logic [CH_W-1:0]     channel;
	logic [FREQ_W-1:0]   frequency_hz;
	logic [PCT_W-1:0]    duty_percent;
	logic                invert_polarity;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [1:0]          status;
	logic [PRESC_W-1:0]  prescale_minus_one;
	logic [CNT16_W-1:0]  period_minus_one;
	logic [CNT16_W-1:0]  active_count;
	logic                active_level;

	// bench copy of the engine state
	longint unsigned     src_clock_hz;
	int unsigned         chan_period [CHANNELS];
	int unsigned         chan_prescale [CHANNELS];
	logic                chan_high [CHANNELS];
	logic [CHANNELS-1:0] chan_configured;

	pwm_result_t expected_results[$];

	bit no_idle;
	int requests_sent;
	int results_checked;
	int mismatch_count;
	int clock_settings;
	int cycle_count = 0;
	int status_seen [4];

	pwm_prescale_period_duty_calc DUT (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_wr_en          (cfg_wr_en),
		.cfg_wr_data        (cfg_wr_data),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.action             (action),
		.channel            (channel),
		.frequency_hz       (frequency_hz),
		.duty_percent       (duty_percent),
		.invert_polarity    (invert_polarity),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.status             (status),
		.prescale_minus_one (prescale_minus_one),
		.period_minus_one   (period_minus_one),
		.active_count       (active_count),
		.active_level       (active_level)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t ns: timeout after %0d cycles", $time, cycle_count);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// result side stalls at random unless the no-idle stretch is on
	always @(posedge clk) begin
		out_ready <= no_idle || ($urandom_range(0, 99) >= 30);
	end

	// prescale k and period n for a wanted frequency, 0 when not reachable
	function automatic bit solve_divider(input logic [FREQ_W-1:0] freq,
			output int unsigned k, output int unsigned n);
		longint unsigned quot;
		longint unsigned kk;
		longint unsigned nn;
		k = 0;
		n = 0;
		if (freq == 0)
			return 1'b0;
		quot = src_clock_hz / freq;
		if (quot == 0)
			return 1'b0;
		kk = (quot + PERIOD_MAX - 1) / PERIOD_MAX;
		if (kk == 0 || kk > PRESCALE_LIMIT)
			return 1'b0;
		nn = src_clock_hz / (kk * freq);
		if (nn == 0 || nn >= PERIOD_MAX)
			return 1'b0;
		k = 32'(kk);
		n = 32'(nn);
		return 1'b1;
	endfunction

	function automatic pwm_result_t pack_result(status_t st, int unsigned k,
			int unsigned n, int unsigned active, logic high);
		pwm_result_t res;
		res.status = st;
		res.prescale_m1 = (k == 0) ? '0 : PRESC_W'(k - 1);
		res.period_m1 = (n == 0) ? '0 : CNT16_W'(n - 1);
		res.active = CNT16_W'(active);
		res.high = high;
		return res;
	endfunction

	// predicts the result of one request and updates the bench state
	function automatic pwm_result_t predict_pwm_setting(action_t act,
			logic [CH_W-1:0] ch, logic [FREQ_W-1:0] freq,
			logic [PCT_W-1:0] pct, logic inv);
		int unsigned k;
		int unsigned n;
		int unsigned pct_used;
		if (act == ACT_NONE)
			return '0;
		if (ch >= CHANNELS)
			return pack_result(STAT_NO_CHAN, 0, 0, 0, 1'b0);
		if (act == ACT_CONFIG) begin
			if (!solve_divider(freq, k, n))
				return pack_result(STAT_BAD_FREQ, 0, 0, 0, 1'b0);
			chan_prescale[ch] = k;
			chan_period[ch] = n;
			chan_high[ch] = !inv;
			chan_configured[ch] = 1'b1;
			return pack_result(STAT_OK, k, n, 0, chan_high[ch]);
		end
		if (!chan_configured[ch])
			return pack_result(STAT_NO_CHAN, 0, 0, 0, 1'b0);
		// zero frequency on set frequency acts as a 0 percent duty write
		if (act == ACT_DUTY || freq == 0) begin
			pct_used = (act == ACT_FREQ) ? 0 : 32'(pct);
			if (pct_used > PCT_FULL)
				return pack_result(STAT_BAD_PCT, 0, 0, 0, 1'b0);
			n = chan_period[ch];
			return pack_result(STAT_OK, chan_prescale[ch], n,
				(pct_used * n) / PCT_FULL, chan_high[ch]);
		end
		if (!solve_divider(freq, k, n))
			return pack_result(STAT_BAD_FREQ, 0, 0, 0, 1'b0);
		chan_prescale[ch] = k;
		chan_period[ch] = n;
		return pack_result(STAT_OK, k, n, (n * HALF_DUTY) / PCT_FULL, chan_high[ch]);
	endfunction

	function automatic void check_field(string field, longint unsigned want,
			longint unsigned got);
		if (want != got) begin
			$display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk) begin : result_check
		pwm_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t ns: result with nothing expected, status %0d", $time, status);
				mismatch_count++;
			end else begin
				want = expected_results.pop_front();
				check_field("status", 64'(want.status), 64'(status));
				check_field("prescale_minus_one", 64'(want.prescale_m1),
					64'(prescale_minus_one));
				check_field("period_minus_one", 64'(want.period_m1),
					64'(period_minus_one));
				check_field("active_count", 64'(want.active), 64'(active_count));
				check_field("active_level", 64'(want.high), 64'(active_level));
				results_checked++;
				status_seen[status]++;
			end
		end
	end

	// called at a rising edge; leaves valid high after the item is taken
	task automatic send_request(action_t act, logic [CH_W-1:0] ch,
			logic [FREQ_W-1:0] freq, logic [PCT_W-1:0] pct, logic inv);
		while (!no_idle && $urandom_range(0, 99) < 30) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		channel <= ch;
		frequency_hz <= freq;
		duty_percent <= pct;
		invert_polarity <= inv;
		do
			@(posedge clk);
		while (!in_ready);
		expected_results.push_back(predict_pwm_setting(act, ch, freq, pct, inv));
		requests_sent++;
	endtask

	task automatic send_random_request();
		action_t          act;
		logic [CH_W-1:0]  ch;
		logic [FREQ_W-1:0] freq;
		logic [PCT_W-1:0] pct;
		logic             inv;
		int               pick;
		int               span;
		pick = $urandom_range(0, 99);
		if (pick < 30)
			act = ACT_CONFIG;
		else if (pick < 62)
			act = ACT_DUTY;
		else if (pick < 94)
			act = ACT_FREQ;
		else
			act = ACT_NONE;
		ch = CH_W'($urandom_range(0, CHANNELS - 1));
		pick = $urandom_range(0, 99);
		if (pick < 4) begin
			freq = '0;
		end else if (pick < 12) begin
			freq = FREQ_W'($urandom);
		end else if (pick < 20) begin
			freq = FREQ_W'($urandom_range(1, 4));
		end else begin
			// spread over magnitudes so every prescale range gets hit
			span = $urandom_range(0, FREQ_W - 1);
			freq = FREQ_W'($urandom_range(1, 1 << span));
		end
		if ($urandom_range(0, 99) < 85)
			pct = PCT_W'($urandom_range(0, PCT_FULL));
		else
			pct = PCT_W'($urandom_range(PCT_FULL + 1, PCT_TOP));
		inv = 1'($urandom_range(0, 1));
		send_request(act, ch, freq, pct, inv);
	endtask

	task automatic wait_engine_idle();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_source_clock(logic [FREQ_W-1:0] value);
		wait_engine_idle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		src_clock_hz = 64'(value);
		clock_settings++;
	endtask

	task automatic test_random_traffic(int count);
		repeat (count)
			send_random_request();
	endtask

	// default 24 MHz source: errors, extremes and every action
	task automatic test_directed_actions();
		send_request(ACT_DUTY, 3'd3, 27'd1000, 7'd50, 1'b0);
		send_request(ACT_FREQ, 3'd3, 27'd1000, 7'd0, 1'b0);
		send_request(ACT_FREQ, 3'd3, 27'd0, 7'd127, 1'b1);
		send_request(ACT_CONFIG, 3'd0, 27'd0, 7'd0, 1'b0);
		send_request(ACT_CONFIG, 3'd0, 27'd24000001, 7'd0, 1'b0);
		send_request(ACT_CONFIG, 3'd0, 27'd1, 7'd0, 1'b0);
		send_request(ACT_CONFIG, 3'd0, 27'd100000000, 7'd0, 1'b1);
		send_request(ACT_CONFIG, 3'd0, '1, '1, 1'b1);
		send_request(ACT_CONFIG, 3'd0, 27'd24000000, 7'd0, 1'b0);
		send_request(ACT_CONFIG, 3'd1, 27'd366, 7'd0, 1'b1);
		send_request(ACT_CONFIG, 3'd2, 27'd367, 7'd0, 1'b0);
		send_request(ACT_CONFIG, 3'd7, 27'd25000, 7'd0, 1'b1);
		send_request(ACT_CONFIG, 3'd4, 27'd92, 7'd0, 1'b0);
		send_request(ACT_DUTY, 3'd1, 27'd0, 7'd0, 1'b0);
		send_request(ACT_DUTY, 3'd1, 27'd0, 7'd100, 1'b0);
		send_request(ACT_DUTY, 3'd1, 27'd0, 7'd101, 1'b0);
		send_request(ACT_DUTY, 3'd1, '1, 7'd127, 1'b1);
		send_request(ACT_DUTY, 3'd0, 27'd0, 7'd50, 1'b0);
		send_request(ACT_FREQ, 3'd2, 27'd0, 7'd100, 1'b0);
		// unreachable frequency must leave the old period in place
		send_request(ACT_FREQ, 3'd2, 27'd1, 7'd0, 1'b0);
		send_request(ACT_DUTY, 3'd2, 27'd0, 7'd100, 1'b0);
		send_request(ACT_FREQ, 3'd7, 27'd1000, 7'd0, 1'b0);
		send_request(ACT_NONE, '1, '1, '1, 1'b1);
	endtask

	task automatic test_fastest_clock();
		write_source_clock(27'd100000000);
		no_idle = 1'b1;
		test_random_traffic(220);
		no_idle = 1'b0;
	endtask

	task automatic test_slowest_clock();
		write_source_clock(27'd1);
		send_request(ACT_CONFIG, 3'd5, 27'd1, 7'd0, 1'b0);
		send_request(ACT_CONFIG, 3'd5, 27'd2, 7'd0, 1'b0);
		test_random_traffic(50);
	endtask

	task automatic test_deepest_prescale();
		write_source_clock(27'd134000000);
		send_request(ACT_CONFIG, 3'd5, 27'd8, 7'd0, 1'b1);
		send_request(ACT_CONFIG, 3'd5, 27'd7, 7'd0, 1'b0);
		test_random_traffic(180);
	endtask

	task automatic test_period_limits();
		// period lands exactly on the limit
		write_source_clock(27'd6553500);
		send_request(ACT_CONFIG, 3'd6, 27'd100, 7'd0, 1'b0);
		// largest period that fits
		write_source_clock(27'd6553400);
		send_request(ACT_CONFIG, 3'd6, 27'd100, 7'd0, 1'b1);
		send_request(ACT_DUTY, 3'd6, 27'd0, 7'd100, 1'b0);
		send_request(ACT_FREQ, 3'd6, 27'd100, 7'd0, 1'b0);
		test_random_traffic(100);
	endtask

	task automatic test_zero_and_full_clock();
		write_source_clock('0);
		send_request(ACT_CONFIG, 3'd3, 27'd1, 7'd0, 1'b0);
		test_random_traffic(25);
		write_source_clock('1);
		test_random_traffic(130);
	endtask

	task automatic test_back_to_reset_clock();
		write_source_clock(FREQ_W'(CLOCK_RESET));
		test_random_traffic(250);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		action = ACT_NONE;
		channel = '0;
		frequency_hz = '0;
		duty_percent = '0;
		invert_polarity = 1'b0;
		no_idle = 1'b0;
		requests_sent = 0;
		results_checked = 0;
		mismatch_count = 0;
		clock_settings = 1;
		status_seen = '{default: 0};
		src_clock_hz = 64'(CLOCK_RESET);
		chan_configured = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			chan_period[i] = 0;
			chan_prescale[i] = 0;
			chan_high[i] = 1'b0;
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_actions();
		test_random_traffic(350);
		test_fastest_clock();
		test_slowest_clock();
		test_deepest_prescale();
		test_period_limits();
		test_zero_and_full_clock();
		test_back_to_reset_clock();

		wait_engine_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d requests over %0d source clock settings, %0d results checked",
			requests_sent, clock_settings, results_checked);
		$display("status mix: ok %0d, bad frequency %0d, bad percent %0d, not configured %0d",
			status_seen[STAT_OK], status_seen[STAT_BAD_FREQ],
			status_seen[STAT_BAD_PCT], status_seen[STAT_NO_CHAN]);
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
